### sv/gb5_pkg.sv
// Shared types and constants of the 5x5 Gaussian blur stream unit.
// Used by gb5_front, gb5_queue, gb5_back and the top level; no dependencies.
package gb5_pkg;

  localparam int unsigned MAX_LINE_DEF = 1024;
  localparam int unsigned KSIZE        = 5;
  localparam int unsigned STORE_ROWS   = KSIZE - 1;
  localparam int unsigned SAMPLE_W     = 24;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned ROWS_W       = 16;
  localparam int unsigned VROW_W       = ROWS_W + 1;
  localparam int unsigned WGT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned GRP_W        = SAMPLE_W + 2;
  localparam int unsigned SUM_W        = SAMPLE_W + 3;
  localparam int unsigned PROD_W       = SUM_W + WGT_W + 1;
  localparam int unsigned PAIR_W       = PROD_W + 1;
  localparam int unsigned ACC_W        = PROD_W + 3;
  localparam int unsigned FRAC_SHIFT   = 16;

  localparam logic [LEN_W-1:0]  LINE_LENGTH_RST = LEN_W'(1024);
  localparam logic [ROWS_W-1:0] LINE_TOTAL_RST  = ROWS_W'(1024);
  localparam logic [WGT_W-1:0]  W_CENTER_RST    = WGT_W'(10623);
  localparam logic [WGT_W-1:0]  W_EDGE1_RST     = WGT_W'(6444);
  localparam logic [WGT_W-1:0]  W_DIAG1_RST     = WGT_W'(3908);
  localparam logic [WGT_W-1:0]  W_EDGE2_RST     = WGT_W'(1438);
  localparam logic [WGT_W-1:0]  W_KNIGHT_RST    = WGT_W'(872);
  localparam logic [WGT_W-1:0]  W_CORNER_RST    = WGT_W'(195);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LENGTH = 3'd0,
    REG_LINE_TOTAL  = 3'd1,
    REG_W_CENTER    = 3'd2,
    REG_W_EDGE1     = 3'd3,
    REG_W_DIAG1     = 3'd4,
    REG_W_EDGE2     = 3'd5,
    REG_W_KNIGHT    = 3'd6,
    REG_W_CORNER    = 3'd7
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Frame geometry as seen by the front; clear marks a geometry write.
  typedef struct packed {
    logic [LEN_W-1:0]  line_length;
    logic [ROWS_W-1:0] line_total;
    logic              clear;
  } geom_t;

  typedef struct packed {
    logic [WGT_W-1:0] center;
    logic [WGT_W-1:0] edge1;
    logic [WGT_W-1:0] diag1;
    logic [WGT_W-1:0] edge2;
    logic [WGT_W-1:0] knight;
    logic [WGT_W-1:0] corner;
  } weights_t;

  // One window column (row KSIZE-1 newest) plus what the back needs to emit.
  typedef struct packed {
    logic                              emit;
    logic                              last;
    logic [KSIZE-1:0]                  rmask;
    logic [KSIZE-1:0]                  cmask;
    logic [KSIZE-1:0][SAMPLE_W-1:0]    col;
  } col_item_t;

endpackage

### sv/gb5_queue.sv
// Short FIFO of window columns between the front and the back.
// Depends on gb5_pkg for the item type.
module gb5_queue #(
  parameter int unsigned DEPTH = gb5_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  gb5_pkg::col_item_t          push_item,
  input  logic                        pop,
  output gb5_pkg::col_item_t          head,
  output logic                        empty,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gb5_pkg::col_item_t         store_r [DEPTH];
  logic [PW-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(DEPTH+1)-1:0] count_r, count_nxt;

  assign head  = store_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/gb5_front.sv
// Front of the blur unit: raster position tracking, item classification and
// the four-row line store. Pushes one window column per fed position into gb5_queue.
// Depends on gb5_pkg.
module gb5_front #(
  parameter int unsigned MAX_LINE = gb5_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gb5_pkg::geom_t                geom,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  gb5_pkg::sample_t              in_sample,
  input  logic [gb5_pkg::QCNT_W-1:0]    q_count,
  output logic                          q_push,
  output gb5_pkg::col_item_t            q_item
);

  localparam int unsigned CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int unsigned XW = ((CW > gb5_pkg::LEN_W) ? CW : gb5_pkg::LEN_W) + 1;
  localparam int unsigned LW = XW + 1;
  localparam int unsigned SW = gb5_pkg::SAMPLE_W;
  localparam int unsigned NR = gb5_pkg::STORE_ROWS;

  typedef logic [NR-1:0][SW-1:0] stack_t;

  // Store entry per column: slot 0 holds the previous row, slot NR-1 the oldest.
  stack_t                        mem [MAX_LINE];

  logic [CW-1:0]                 p_col_r, p_col_nxt;
  logic [gb5_pkg::VROW_W-1:0]    p_row_r, p_row_nxt;
  logic [CW-1:0]                 m_col_r, m_col_nxt;
  logic [gb5_pkg::ROWS_W-1:0]    m_row_r, m_row_nxt;
  logic [LW-1:0]                 lead_r, lead_nxt;

  logic                          s1_v_r;
  logic [CW-1:0]                 s1_col_r;
  gb5_pkg::sample_t              s1_new_r;
  logic                          s1_emit_r;
  logic                          s1_last_r;
  logic [gb5_pkg::KSIZE-1:0]     s1_rmask_r;
  logic [gb5_pkg::KSIZE-1:0]     s1_cmask_r;
  stack_t                        rd_r;
  logic                          fwd_v_r;
  stack_t                        fwd_d_r;

  logic [XW-1:0]                 w_eff;
  logic [gb5_pkg::ROWS_W-1:0]    h_eff;
  logic [LW-1:0]                 lead_cap;
  logic                          frame_done;
  logic                          lead_full;
  logic                          space;
  logic                          pad_need;
  logic                          pad_go;
  logic                          acc;
  logic                          feed;
  logic                          emit;
  logic                          last;
  logic                          p_col_end;
  logic                          m_col_end;
  gb5_pkg::sample_t              new_sample;
  logic [gb5_pkg::KSIZE-1:0]     rmask;
  logic [gb5_pkg::KSIZE-1:0]     cmask;
  stack_t                        slots;
  stack_t                        wentry;

  always_comb begin
    if (geom.line_length == '0) begin
      w_eff = XW'(1);
    end else if (32'(geom.line_length) > 32'(MAX_LINE)) begin
      w_eff = XW'(MAX_LINE);
    end else begin
      w_eff = XW'(geom.line_length);
    end
    h_eff = (geom.line_total == '0) ? gb5_pkg::ROWS_W'(1) : geom.line_total;
  end

  assign lead_cap   = LW'({w_eff, 1'b0}) + LW'(2);
  assign lead_full  = (lead_r == lead_cap);
  assign frame_done = (p_row_r >= gb5_pkg::VROW_W'(h_eff));
  assign space      = (32'(q_count) + 32'(s1_v_r)) < 32'(gb5_pkg::QUEUE_DEPTH);
  // A small frame ends before the window has caught up: feed zeros on our own.
  assign pad_need   = frame_done && !lead_full;
  assign pad_go     = pad_need && space;
  assign in_ready   = space && !pad_need;
  assign acc        = in_valid && in_ready;
  assign feed       = pad_go || (acc && ((!in_cmd && !frame_done) || (in_cmd && frame_done)));
  assign emit       = feed && !pad_go && lead_full;
  assign p_col_end  = (XW'(p_col_r) + XW'(1) == w_eff);
  assign m_col_end  = (XW'(m_col_r) + XW'(1) == w_eff);
  assign last       = emit && m_col_end && (m_row_r == h_eff - 1'b1);
  assign new_sample = (acc && !in_cmd) ? in_sample : '0;

  always_comb begin
    rmask[0] = (m_row_r >= gb5_pkg::ROWS_W'(2));
    rmask[1] = (m_row_r >= gb5_pkg::ROWS_W'(1));
    rmask[2] = 1'b1;
    rmask[3] = ((gb5_pkg::VROW_W'(m_row_r) + gb5_pkg::VROW_W'(1)) < gb5_pkg::VROW_W'(h_eff));
    rmask[4] = ((gb5_pkg::VROW_W'(m_row_r) + gb5_pkg::VROW_W'(2)) < gb5_pkg::VROW_W'(h_eff));
    cmask[0] = (m_col_r >= CW'(2));
    cmask[1] = (m_col_r >= CW'(1));
    cmask[2] = 1'b1;
    cmask[3] = ((XW'(m_col_r) + XW'(1)) < w_eff);
    cmask[4] = ((XW'(m_col_r) + XW'(2)) < w_eff);
  end

  always_comb begin
    p_col_nxt = p_col_r;
    p_row_nxt = p_row_r;
    m_col_nxt = m_col_r;
    m_row_nxt = m_row_r;
    lead_nxt  = lead_r;
    if (feed) begin
      if (p_col_end) begin
        p_col_nxt = '0;
        p_row_nxt = p_row_r + 1'b1;
      end else begin
        p_col_nxt = p_col_r + 1'b1;
      end
      if (!lead_full) begin
        lead_nxt = lead_r + 1'b1;
      end
    end
    if (emit) begin
      if (m_col_end) begin
        m_col_nxt = '0;
        m_row_nxt = m_row_r + 1'b1;
      end else begin
        m_col_nxt = m_col_r + 1'b1;
      end
    end
    // Frame finished or geometry rewritten: start over at the top left.
    if (last || geom.clear) begin
      p_col_nxt = '0;
      p_row_nxt = '0;
      m_col_nxt = '0;
      m_row_nxt = '0;
      lead_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_col_r <= '0;
      p_row_r <= '0;
      m_col_r <= '0;
      m_row_r <= '0;
      lead_r  <= '0;
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      p_col_r <= p_col_nxt;
      p_row_r <= p_row_nxt;
      m_col_r <= m_col_nxt;
      m_row_r <= m_row_nxt;
      lead_r  <= lead_nxt;
      s1_v_r  <= feed;
      fwd_v_r <= feed && s1_v_r && (p_col_r == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (feed) begin
      s1_col_r   <= p_col_r;
      s1_new_r   <= new_sample;
      s1_emit_r  <= emit;
      s1_last_r  <= last;
      s1_rmask_r <= rmask;
      s1_cmask_r <= cmask;
    end
    fwd_d_r <= wentry;
  end

  // Line store: read the column at acceptance, write it back in the following cycle.
  always_ff @(posedge clk) begin
    rd_r <= mem[p_col_r];
    if (s1_v_r) begin
      mem[s1_col_r] <= wentry;
    end
  end

  assign slots = fwd_v_r ? fwd_d_r : rd_r;

  always_comb begin
    wentry[0] = s1_new_r;
    for (int i = 1; i < NR; i++) begin
      wentry[i] = slots[i-1];
    end
  end

  always_comb begin
    q_item.emit  = s1_emit_r;
    q_item.last  = s1_last_r;
    q_item.rmask = s1_rmask_r;
    q_item.cmask = s1_cmask_r;
    q_item.col[gb5_pkg::KSIZE-1] = s1_new_r;
    for (int k = 0; k < NR; k++) begin
      q_item.col[k] = slots[NR-1-k];
    end
  end

  assign q_push = s1_v_r;

endmodule

### sv/gb5_back.sv
// Back of the blur unit: 5x5 window, symmetric weight groups, multiply,
// accumulate, round and saturate into the output register. Depends on gb5_pkg.
module gb5_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gb5_pkg::weights_t    weights,
  input  gb5_pkg::col_item_t   head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gb5_pkg::sample_t     out_sample,
  output logic                 out_last
);

  localparam int unsigned K  = gb5_pkg::KSIZE;
  localparam int unsigned SW = gb5_pkg::SAMPLE_W;
  localparam int unsigned GW = gb5_pkg::GRP_W;
  localparam int unsigned UW = gb5_pkg::SUM_W;
  localparam int unsigned PW = gb5_pkg::PROD_W;
  localparam int unsigned AW = gb5_pkg::PAIR_W;
  localparam int unsigned CW = gb5_pkg::ACC_W;
  localparam int unsigned RW = CW - gb5_pkg::FRAC_SHIFT;
  localparam int unsigned WGT_ALIAS_W = gb5_pkg::WGT_W + 1;

  function automatic logic signed [GW-1:0] sum4(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b,
                                                input logic signed [SW-1:0] c,
                                                input logic signed [SW-1:0] d);
    logic signed [GW-1:0] ab;
    logic signed [GW-1:0] cd;
    ab = GW'(a) + GW'(b);
    cd = GW'(c) + GW'(d);
    return ab + cd;
  endfunction

  logic [K-1:0][K-1:0][SW-1:0]  win_r;
  logic                         en;
  logic                         b1_v_r, b2_v_r, b3_v_r, b4_v_r, b5_v_r, b6_v_r;
  logic                         b1_last_r, b2_last_r, b3_last_r, b4_last_r, b5_last_r, b6_last_r;
  logic [K-1:0]                 b1_rmask_r;
  logic [K-1:0]                 b1_cmask_r;
  logic signed [SW-1:0]         mv [K][K];
  logic signed [GW-1:0]         g_r [7];
  logic signed [UW-1:0]         s_r [6];
  logic signed [PW-1:0]         p_r [6];
  logic signed [AW-1:0]         t_r [3];
  logic signed [CW-1:0]         acc_r;
  logic signed [CW-1:0]         biased;
  logic signed [RW-1:0]         rnd;
  logic signed [WGT_ALIAS_W-1:0] wv [6];
  logic                         out_valid_r;
  gb5_pkg::sample_t             out_sample_r;
  logic                         out_last_r;

  // Advance the whole pipeline unless the output register is held.
  assign en  = !out_valid_r || out_ready;
  assign pop = en && !empty;

  always_comb begin
    for (int k = 0; k < K; k++) begin
      for (int j = 0; j < K; j++) begin
        mv[k][j] = (b1_rmask_r[k] && b1_cmask_r[j]) ? $signed(win_r[k][j]) : '0;
      end
    end
  end

  always_comb begin
    wv[0] = $signed({1'b0, weights.center});
    wv[1] = $signed({1'b0, weights.edge1});
    wv[2] = $signed({1'b0, weights.diag1});
    wv[3] = $signed({1'b0, weights.edge2});
    wv[4] = $signed({1'b0, weights.knight});
    wv[5] = $signed({1'b0, weights.corner});
  end

  assign biased = acc_r + CW'(32768);
  assign rnd    = RW'(biased >>> gb5_pkg::FRAC_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      b3_v_r      <= 1'b0;
      b4_v_r      <= 1'b0;
      b5_v_r      <= 1'b0;
      b6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_v_r      <= pop && head.emit;
      b2_v_r      <= b1_v_r;
      b3_v_r      <= b2_v_r;
      b4_v_r      <= b3_v_r;
      b5_v_r      <= b4_v_r;
      b6_v_r      <= b5_v_r;
      out_valid_r <= b6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < K; k++) begin
        for (int j = 0; j < K - 1; j++) begin
          win_r[k][j] <= win_r[k][j+1];
        end
        win_r[k][K-1] <= head.col[k];
      end
    end
    if (en) begin
      b1_rmask_r <= head.rmask;
      b1_cmask_r <= head.cmask;
      b1_last_r  <= head.last;
      b2_last_r  <= b1_last_r;
      b3_last_r  <= b2_last_r;
      b4_last_r  <= b3_last_r;
      b5_last_r  <= b4_last_r;
      b6_last_r  <= b5_last_r;
      out_last_r <= b6_last_r;
      // group taps that share a weight
      g_r[0] <= GW'(mv[2][2]);
      g_r[1] <= sum4(mv[1][2], mv[3][2], mv[2][1], mv[2][3]);
      g_r[2] <= sum4(mv[1][1], mv[1][3], mv[3][1], mv[3][3]);
      g_r[3] <= sum4(mv[0][2], mv[4][2], mv[2][0], mv[2][4]);
      g_r[4] <= sum4(mv[0][1], mv[0][3], mv[4][1], mv[4][3]);
      g_r[5] <= sum4(mv[1][0], mv[3][0], mv[1][4], mv[3][4]);
      g_r[6] <= sum4(mv[0][0], mv[0][4], mv[4][0], mv[4][4]);
      s_r[0] <= UW'(g_r[0]);
      s_r[1] <= UW'(g_r[1]);
      s_r[2] <= UW'(g_r[2]);
      s_r[3] <= UW'(g_r[3]);
      s_r[4] <= UW'(g_r[4]) + UW'(g_r[5]);
      s_r[5] <= UW'(g_r[6]);
      for (int i = 0; i < 6; i++) begin
        p_r[i] <= PW'(s_r[i]) * PW'(wv[i]);
      end
      t_r[0] <= AW'(p_r[0]) + AW'(p_r[1]);
      t_r[1] <= AW'(p_r[2]) + AW'(p_r[3]);
      t_r[2] <= AW'(p_r[4]) + AW'(p_r[5]);
      acc_r  <= CW'(t_r[0]) + CW'(t_r[1]) + CW'(t_r[2]);
      if (rnd > RW'(8388607)) begin
        out_sample_r <= 24'sh7FFFFF;
      end else if (rnd < -RW'(8388608)) begin
        out_sample_r <= 24'sh800000;
      end else begin
        out_sample_r <= SW'(rnd);
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

### sv/gaussian_blur_5x5_stream_unit.sv
// Top level of the 5x5 Gaussian blur stream unit: configuration registers and
// the front / queue / back chain. Depends on gb5_pkg, gb5_front, gb5_queue, gb5_back.
//
// Input channel (in_*): one transaction per raster sample; in_tuser = 0 marks a
// frame sample in in_tdata (signed Q15.8), in_tuser = 1 a flush item. After the
// last sample of a frame, send flush items; each one drains one pending output.
// Output channel (out_*): blurred samples in out_tdata, out_tlast on the last
// output of the frame. Output m appears once input m + 2*W + 2 (or a flush) has
// arrived, after passing the column queue and the back's register stages.
// Throughput: one transaction per cycle on both sides while the receiver does not
// stall; the line store reads one column while it writes back another. When a frame is
// shorter than 2*W + 2 samples, the first flush waits while the unit feeds zero
// columns on its own, one per cycle while the column queue has room.
// Configuration (cfg_*): always ready; write only while the unit is idle.
// Writing line_length or line_total restarts the frame; weights act at once.
// Reset restores the default geometry and weights and empties every stage.
// When the receiver stalls, the result is held and the input keeps flowing
// until the column queue fills, then in_tready drops.
module gaussian_blur_5x5_stream_unit #(
  parameter int unsigned MAX_LINE = gb5_pkg::MAX_LINE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // [23:0] sample_in
  input  logic                              in_tuser,   // [0] cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // [23:0] sample_out
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gb5_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [gb5_pkg::LEN_W-1:0]   line_length_r;
  logic [gb5_pkg::ROWS_W-1:0]  line_total_r;
  gb5_pkg::weights_t           weights_r;
  logic                        cfg_wr;
  gb5_pkg::geom_t              geom;
  logic                        q_push;
  gb5_pkg::col_item_t          q_item;
  logic                        q_pop;
  gb5_pkg::col_item_t          q_head;
  logic                        q_empty;
  logic [gb5_pkg::QCNT_W-1:0]  q_count;
  gb5_pkg::sample_t            out_sample;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r    <= gb5_pkg::LINE_LENGTH_RST;
      line_total_r     <= gb5_pkg::LINE_TOTAL_RST;
      weights_r.center <= gb5_pkg::W_CENTER_RST;
      weights_r.edge1  <= gb5_pkg::W_EDGE1_RST;
      weights_r.diag1  <= gb5_pkg::W_DIAG1_RST;
      weights_r.edge2  <= gb5_pkg::W_EDGE2_RST;
      weights_r.knight <= gb5_pkg::W_KNIGHT_RST;
      weights_r.corner <= gb5_pkg::W_CORNER_RST;
    end else if (cfg_wr) begin
      unique case (gb5_pkg::cfg_reg_t'(cfg_index))
        gb5_pkg::REG_LINE_LENGTH: line_length_r    <= cfg_data[gb5_pkg::LEN_W-1:0];
        gb5_pkg::REG_LINE_TOTAL:  line_total_r     <= cfg_data;
        gb5_pkg::REG_W_CENTER:    weights_r.center <= cfg_data;
        gb5_pkg::REG_W_EDGE1:     weights_r.edge1  <= cfg_data;
        gb5_pkg::REG_W_DIAG1:     weights_r.diag1  <= cfg_data;
        gb5_pkg::REG_W_EDGE2:     weights_r.edge2  <= cfg_data;
        gb5_pkg::REG_W_KNIGHT:    weights_r.knight <= cfg_data;
        gb5_pkg::REG_W_CORNER:    weights_r.corner <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.line_length = line_length_r;
    geom.line_total  = line_total_r;
    geom.clear       = cfg_wr && ((gb5_pkg::cfg_reg_t'(cfg_index) == gb5_pkg::REG_LINE_LENGTH) ||
                                  (gb5_pkg::cfg_reg_t'(cfg_index) == gb5_pkg::REG_LINE_TOTAL));
  end

  gb5_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_sample (in_tdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  gb5_queue #(
    .DEPTH (gb5_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  gb5_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .weights    (weights_r),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_sample),
    .out_last   (out_tlast)
  );

  assign out_tdata = out_sample;

endmodule

### tb/gaussian_blur_5x5_stream_unit_test.sv
// Self-checking bench for the 5x5 Gaussian blur stream unit: directed table, then random frames.
// A local pixel predictor checks every output; depends on gb5_pkg and the top level.
module gaussian_blur_5x5_stream_unit_test;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;
  localparam int   LINE_MAX   = 1024;
  localparam int   DEPTH      = 4 * LINE_MAX + 8;
  localparam int   IDLE_LIMIT = 20000;

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_FLUSH} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    gb5_pkg::cfg_reg_t  idx;
    logic [23:0]        data;
    bit                 typed;
    logic [23:0]        exp_pix;
    logic               exp_last;
  } stim_row_t;

  typedef struct {
    logic [23:0] pix;
    logic        last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tuser = 1'b0;
  logic [23:0] in_tdata = '0;
  logic in_tready;
  logic out_tvalid, out_tlast;
  logic [23:0] out_tdata;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gb5_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gaussian_blur_5x5_stream_unit dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [10:0] len_r;
  logic [15:0] tot_r;
  logic [15:0] wgt [6];
  int          store [DEPTH];
  int unsigned col_c, row_c, out_c;

  pixel_t      pending_pix [$];
  stim_row_t   table_rows [$];
  int          errors = 0;
  int          n_items = 0, n_pixels = 0, n_frames = 0, n_cfg = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  function automatic int unsigned eff_w();
    if (len_r == 0) return 1;
    if (len_r > LINE_MAX) return LINE_MAX;
    return len_r;
  endfunction

  function automatic int unsigned eff_h();
    return (tot_r == 0) ? 1 : tot_r;
  endfunction

  function automatic longint tap_weight(int d2);
    case (d2)
      0: return wgt[gb5_pkg::REG_W_CENTER - gb5_pkg::REG_W_CENTER];
      1: return wgt[gb5_pkg::REG_W_EDGE1 - gb5_pkg::REG_W_CENTER];
      2: return wgt[gb5_pkg::REG_W_DIAG1 - gb5_pkg::REG_W_CENTER];
      4: return wgt[gb5_pkg::REG_W_EDGE2 - gb5_pkg::REG_W_CENTER];
      5: return wgt[gb5_pkg::REG_W_KNIGHT - gb5_pkg::REG_W_CENTER];
      8: return wgt[gb5_pkg::REG_W_CORNER - gb5_pkg::REG_W_CENTER];
      default: return 0;
    endcase
  endfunction

  task automatic blur_pixel(input int unsigned w, input int unsigned h, output pixel_t px);
    int unsigned total;
    int mr, mc, rr, cc;
    longint acc, q;
    total = w * h;
    mr = out_c / w;
    mc = out_c % w;
    acc = 0;
    for (int dr = -2; dr <= 2; dr++) begin
      for (int dc = -2; dc <= 2; dc++) begin
        rr = mr + dr;
        cc = mc + dc;
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
          acc += longint'(store[(rr * w + cc) % DEPTH]) * tap_weight(dr * dr + dc * dc);
      end
    end
    q = (acc + 32768) >>> 16;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    px.pix = q[23:0];
    px.last = (out_c == total - 1);
    out_c++;
    if (out_c >= total) begin
      col_c = 0;
      row_c = 0;
      out_c = 0;
    end
  endtask

  // advance the predictor by one accepted input transaction
  task automatic predict_blur(input logic cmd, input logic [23:0] smp,
                              output bit got, output pixel_t px);
    int unsigned w, h, total, received;
    w = eff_w();
    h = eff_h();
    total = w * h;
    received = (row_c >= h) ? total : row_c * w + col_c;
    got = 0;
    if (cmd == CMD_SAMPLE) begin
      if (received >= total) return;
      store[received % DEPTH] = int'(signed'(smp));
      col_c++;
      if (col_c >= w) begin
        col_c = 0;
        row_c++;
      end
      if (received >= 2 * w + 2 && out_c < total) begin
        blur_pixel(w, h, px);
        got = 1;
      end
    end else if (received >= total && out_c < total) begin
      blur_pixel(w, h, px);
      got = 1;
    end
  endtask

  task automatic report(input string what, input logic [23:0] got_v, input logic [23:0] exp_v);
    errors++;
    $display("mismatch %s: got %h expected %h (pixel %0d)", what, got_v, exp_v, n_pixels);
  endtask

  // wait until all pixels are back, then let the pipeline settle
  task automatic wait_drained();
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input gb5_pkg::cfg_reg_t idx, input logic [15:0] val);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      gb5_pkg::REG_LINE_LENGTH: len_r = val[10:0];
      gb5_pkg::REG_LINE_TOTAL:  tot_r = val;
      default:                  wgt[idx - gb5_pkg::REG_W_CENTER] = val;
    endcase
    if (idx == gb5_pkg::REG_LINE_LENGTH || idx == gb5_pkg::REG_LINE_TOTAL) begin
      col_c = 0;
      row_c = 0;
      out_c = 0;
    end
  endtask

  // one input transaction; the sender may idle between bursts
  task automatic send_item(input logic cmd, input logic [23:0] smp, input bit typed,
                           input pixel_t typed_px);
    bit got;
    pixel_t px;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    n_items++;
    predict_blur(cmd, smp, got, px);
    if (typed) pending_pix.push_back(typed_px);
    else if (got) pending_pix.push_back(px);
  endtask

  task automatic add_row(input row_kind_t k, input gb5_pkg::cfg_reg_t idx,
                         input logic [23:0] d, input bit typed, input logic [23:0] ep,
                         input logic el);
    stim_row_t r;
    r.kind = k; r.idx = idx; r.data = d; r.typed = typed; r.exp_pix = ep; r.exp_last = el;
    table_rows.push_back(r);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1: return 24'($signed($urandom_range(0, 131071)) - 65536);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 12000));
    endcase
  endfunction

  // receive side: check, stall pattern, watchdog
  int stall_phase = 0;
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_pixels++;
        if (pending_pix.size() == 0) begin
          report("unexpected pixel", out_tdata, '0);
        end else begin
          e = pending_pix.pop_front();
          if (out_tdata !== e.pix) report("sample_out", out_tdata, e.pix);
          if (out_tlast !== e.last) report("frame_last", {23'd0, out_tlast}, {23'd0, e.last});
        end
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || cfg_valid)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("gaussian_blur_5x5_stream_unit_test NOT OK");
        $finish;
      end
    end
    // long open stretches, then bursts of stalls of random depth
    stall_phase <= (stall_phase + 1) % 97;
    out_tready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
  end

  initial begin
    stim_row_t r;
    pixel_t tp;
    int unsigned w, h, total;
    bit partial;
    len_r = gb5_pkg::LINE_LENGTH_RST;
    tot_r = gb5_pkg::LINE_TOTAL_RST;
    wgt[0] = gb5_pkg::W_CENTER_RST; wgt[1] = gb5_pkg::W_EDGE1_RST;
    wgt[2] = gb5_pkg::W_DIAG1_RST;  wgt[3] = gb5_pkg::W_EDGE2_RST;
    wgt[4] = gb5_pkg::W_KNIGHT_RST; wgt[5] = gb5_pkg::W_CORNER_RST;
    foreach (store[i]) store[i] = 0;
    col_c = 0; row_c = 0; out_c = 0;

    // saturation both ways on a 3x1 frame, then all-zero weights with ignored items
    add_row(ROW_CFG, gb5_pkg::REG_LINE_LENGTH, 24'd3, 1'b0, 24'd0, 1'b0);
    add_row(ROW_CFG, gb5_pkg::REG_LINE_TOTAL, 24'd1, 1'b0, 24'd0, 1'b0);
    for (int i = 2; i < 8; i++)
      add_row(ROW_CFG, gb5_pkg::cfg_reg_t'(i), 24'hFFFF, 1'b0, 24'd0, 1'b0);
    repeat (3) add_row(ROW_SAMPLE, gb5_pkg::REG_LINE_LENGTH, 24'h7FFFFF, 1'b0, 24'd0, 1'b0);
    // frame complete: drop
    add_row(ROW_SAMPLE, gb5_pkg::REG_LINE_LENGTH, 24'h000123, 1'b0, 24'd0, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h7FFFFF, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h7FFFFF, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h7FFFFF, 1'b1);
    repeat (3) add_row(ROW_SAMPLE, gb5_pkg::REG_LINE_LENGTH, 24'h800000, 1'b0, 24'd0, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h800000, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h800000, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h800000, 1'b1);
    for (int i = 2; i < 8; i++)
      add_row(ROW_CFG, gb5_pkg::cfg_reg_t'(i), 24'd0, 1'b0, 24'd0, 1'b0);
    add_row(ROW_SAMPLE, gb5_pkg::REG_LINE_LENGTH, 24'h7FFFFF, 1'b0, 24'd0, 1'b0);
    // frame open: drop
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b0, 24'd0, 1'b0);
    add_row(ROW_SAMPLE, gb5_pkg::REG_LINE_LENGTH, 24'h800000, 1'b0, 24'd0, 1'b0);
    add_row(ROW_SAMPLE, gb5_pkg::REG_LINE_LENGTH, 24'h555555, 1'b0, 24'd0, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h000000, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h000000, 1'b0);
    add_row(ROW_FLUSH, gb5_pkg::REG_LINE_LENGTH, 24'd0, 1'b1, 24'h000000, 1'b1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      r = table_rows[i];
      tp.pix = r.exp_pix;
      tp.last = r.exp_last;
      case (r.kind)
        ROW_CFG:    write_reg(r.idx, r.data[15:0]);
        ROW_SAMPLE: send_item(CMD_SAMPLE, r.data, r.typed, tp);
        default:    send_item(CMD_FLUSH, r.data, r.typed, tp);
      endcase
    end

    // random frames, mostly small; wide lines run as partial frames that get dropped
    tp = '{default: '0};
    while (n_items < 1750) begin
      partial = 0;
      if ($urandom_range(0, 2) == 0 || n_frames == 0) begin
        case ($urandom_range(0, 19))
          0:       write_reg(gb5_pkg::REG_LINE_LENGTH, 16'd0);
          1:       write_reg(gb5_pkg::REG_LINE_LENGTH, $urandom_range(0, 1) ? 16'd2047 : 16'd1024);
          default: write_reg(gb5_pkg::REG_LINE_LENGTH, 16'($urandom_range(1, 12)));
        endcase
        if (eff_w() > 12) begin
          write_reg(gb5_pkg::REG_LINE_TOTAL, 16'($urandom_range(0, 1)));
          partial = 1;
        end else begin
          case ($urandom_range(0, 15))
            0:       write_reg(gb5_pkg::REG_LINE_TOTAL, 16'd0);
            1: begin
              write_reg(gb5_pkg::REG_LINE_TOTAL, 16'hFFFF);
              partial = 1;
            end
            default: write_reg(gb5_pkg::REG_LINE_TOTAL, 16'($urandom_range(1, 8)));
          endcase
        end
        repeat ($urandom_range(0, 3))
          write_reg(gb5_pkg::cfg_reg_t'($urandom_range(gb5_pkg::REG_W_CENTER,
                                                       gb5_pkg::REG_W_CORNER)),
                    rand_weight());
      end
      w = eff_w();
      h = eff_h();
      total = partial ? 150 : w * h;
      for (int k = 0; k < int'(total); k++) begin
        if ($urandom_range(0, 60) == 0) send_item(CMD_FLUSH, 24'($urandom()), 1'b0, tp);
        send_item(CMD_SAMPLE, rand_sample(), 1'b0, tp);
      end
      if (partial) begin
        // drop the open frame with a geometry write once idle
        write_reg(gb5_pkg::REG_LINE_TOTAL, 16'($urandom_range(1, 4)));
      end else begin
        if ($urandom_range(0, 9) == 0) send_item(CMD_SAMPLE, rand_sample(), 1'b0, tp);
        do send_item(CMD_FLUSH, 24'($urandom()), 1'b0, tp);
        while (!(col_c == 0 && row_c == 0 && out_c == 0));
        n_frames++;
      end
    end
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (30) @(posedge clk);

    $display("covered %0d input items, %0d frames, %0d register writes", n_items, n_frames, n_cfg);
    $display("checked %0d blurred pixels, %0d mismatches", n_pixels, errors);
    if (errors == 0 && pending_pix.size() == 0) begin
      $display("gaussian_blur_5x5_stream_unit_test OK");
    end else begin
      $display("gaussian_blur_5x5_stream_unit_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
sv/gb5_pkg.sv
sv/gb5_queue.sv
sv/gb5_front.sv
sv/gb5_back.sv
sv/gaussian_blur_5x5_stream_unit.sv
tb/gaussian_blur_5x5_stream_unit_test.sv
